/* src/mgq_pkg.sv */
// Shared types, codes and helpers for the MIDI gate event queue.
`timescale 1ns / 1ps
package mgq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

	typedef logic [QPTR_W-1:0]  qptr_t;
	typedef logic [CMDQ_AW-1:0] cmdq_ptr_t;
	typedef logic [CMDQ_CW-1:0] cmdq_cnt_t;

	localparam logic OP_MSG = 1'b0;
	localparam logic OP_POP = 1'b1;

	localparam logic [1:0] MSG_NOTE_ON  = 2'd0;
	localparam logic [1:0] MSG_NOTE_OFF = 2'd1;
	localparam logic [1:0] MSG_STOP     = 2'd2;
	localparam logic [1:0] MSG_OTHER    = 2'd3;

	localparam logic [1:0] KIND_ON   = 2'd0;
	localparam logic [1:0] KIND_OFF  = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	localparam logic [1:0] CMD_NOP  = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PUSH = 2'd2;

	localparam logic [1:0] GATE_KEEP  = 2'd0;
	localparam logic [1:0] GATE_OPEN  = 2'd1;
	localparam logic [1:0] GATE_CLOSE = 2'd2;
	localparam logic [1:0] GATE_CLEAR = 2'd3;

	localparam logic [4:0] GATE_CH_LO = 5'd3;
	localparam logic [4:0] GATE_CH_HI = 5'd5;

	typedef struct packed {
		logic        op;
		logic [1:0]  msg_type;
		logic [4:0]  channel;
		logic [6:0]  data_one;
		logic [6:0]  data_two;
		logic [31:0] time_stamp;
	} mgq_in_t;

	typedef struct packed {
		logic [2:0]  gate_bits;
		logic        queue_empty;
		logic [31:0] head_time;
		logic [4:0]  head_channel;
		logic [6:0]  head_note;
		logic [6:0]  head_velocity;
		logic [1:0]  head_kind;
	} mgq_out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  velocity;
		logic [6:0]  note;
		logic [4:0]  channel;
		logic [31:0] time_stamp;
	} mgq_event_t;

	localparam int EVENT_W = $bits(mgq_event_t);

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] gate_op;
		logic [1:0] gate_idx;
		mgq_event_t ev;
	} mgq_cmd_t;

	function automatic qptr_t qptr_next(qptr_t p);
		return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
	endfunction

endpackage

/* src/mgq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mgq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/mgq_front.sv */
// Front end: accepts input transactions and classifies them into commands.
`timescale 1ns / 1ps
module mgq_front (
	input  logic             start,
	input  mgq_pkg::mgq_in_t item,
	input  logic             cmdq_full,
	output logic             busy,
	output logic             cmdq_wr,
	output mgq_pkg::mgq_cmd_t cmd
);
	import mgq_pkg::*;

	logic       gate_hit;
	logic [1:0] ch_off;

	assign busy    = cmdq_full;
	assign cmdq_wr = start && !cmdq_full;

	assign gate_hit = (item.channel >= GATE_CH_LO) && (item.channel <= GATE_CH_HI);
	assign ch_off   = 2'(item.channel - GATE_CH_LO);

	always_comb begin
		cmd                = '0;
		cmd.kind           = CMD_NOP;
		cmd.gate_op        = GATE_KEEP;
		cmd.gate_idx       = ch_off;
		cmd.ev.time_stamp  = item.time_stamp;
		cmd.ev.channel     = item.channel;
		cmd.ev.note        = item.data_one;
		cmd.ev.velocity    = item.data_two;
		cmd.ev.kind        = KIND_ON;
		if (item.op == OP_POP) begin
			cmd.kind = CMD_POP;
		end else begin
			unique case (item.msg_type)
				MSG_NOTE_ON: begin
					cmd.kind = CMD_PUSH;
					// zero velocity means note-off
					if (item.data_two == 7'd0) begin
						cmd.ev.kind = KIND_OFF;
						cmd.gate_op = gate_hit ? GATE_CLOSE : GATE_KEEP;
					end else begin
						cmd.ev.kind = KIND_ON;
						cmd.gate_op = gate_hit ? GATE_OPEN : GATE_KEEP;
					end
				end
				MSG_NOTE_OFF: begin
					cmd.kind    = CMD_PUSH;
					cmd.ev.kind = KIND_OFF;
					cmd.gate_op = gate_hit ? GATE_CLOSE : GATE_KEEP;
				end
				MSG_STOP: begin
					cmd.kind        = CMD_PUSH;
					cmd.ev.kind     = KIND_STOP;
					cmd.ev.note     = 7'd0;
					cmd.ev.velocity = 7'd0;
					cmd.gate_op     = GATE_CLEAR;
				end
				MSG_OTHER: begin
					cmd.kind = CMD_NOP;
				end
				default: begin
					cmd.kind = CMD_NOP;
				end
			endcase
		end
	end

endmodule

/* src/mgq_cmdq.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module mgq_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  mgq_pkg::mgq_cmd_t wcmd,
	input  logic              rd,
	output logic              full,
	output logic              nonempty,
	output mgq_pkg::mgq_cmd_t rcmd
);
	import mgq_pkg::*;

	mgq_cmd_t  slot_q [CMDQ_DEPTH];
	cmdq_ptr_t wptr_q;
	cmdq_ptr_t rptr_q;
	cmdq_cnt_t cnt_q;

	logic do_wr;
	logic do_rd;

	assign full     = (cnt_q == cmdq_cnt_t'(CMDQ_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rcmd     = slot_q[rptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;

	function automatic cmdq_ptr_t ptr_next(cmdq_ptr_t p);
		return (p == cmdq_ptr_t'(CMDQ_DEPTH - 1)) ? '0 : p + cmdq_ptr_t'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wcmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (do_rd) begin
				rptr_q <= ptr_next(rptr_q);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + cmdq_cnt_t'(1);
				2'b01:   cnt_q <= cnt_q - cmdq_cnt_t'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/mgq_back.sv */
// Back end: executes commands on the event ring and gate flags, emits results.
`timescale 1ns / 1ps
module mgq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  mgq_pkg::mgq_cmd_t cmd,
	output logic              cmd_rd,
	output logic              done,
	output mgq_pkg::mgq_out_t result
);
	import mgq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	qptr_t      wptr_q;
	qptr_t      rptr_q;
	logic [2:0] gates_q;
	logic       done_q;
	mgq_out_t   res_q;

	logic       exec;
	logic       ram_we;
	logic [EVENT_W-1:0] ram_rdata;
	mgq_event_t head_ev;
	logic [2:0] gate_bit;
	logic       empty;

	assign exec     = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_rd   = exec;
	assign ram_we   = exec && (cmd.kind == CMD_PUSH);
	assign head_ev  = mgq_event_t'(ram_rdata);
	assign gate_bit = 3'b001 << cmd.gate_idx;
	assign empty    = (wptr_q == rptr_q);
	assign done     = done_q;
	assign result   = res_q;

	mgq_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (cmd.ev),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wptr_q  <= '0;
			rptr_q  <= '0;
			gates_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_READ;
						unique case (cmd.kind)
							CMD_PUSH: begin
								// drop the oldest event when the ring is full
								if (qptr_next(wptr_q) == rptr_q) begin
									rptr_q <= qptr_next(rptr_q);
								end
								wptr_q <= qptr_next(wptr_q);
							end
							CMD_POP: begin
								if (!empty) begin
									rptr_q <= qptr_next(rptr_q);
								end
							end
							default: begin
							end
						endcase
						unique case (cmd.gate_op)
							GATE_OPEN:  gates_q <= gates_q | gate_bit;
							GATE_CLOSE: gates_q <= gates_q & ~gate_bit;
							GATE_CLEAR: gates_q <= '0;
							default:    gates_q <= gates_q;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			res_q.gate_bits   <= gates_q;
			res_q.queue_empty <= empty;
			if (empty) begin
				res_q.head_time     <= '0;
				res_q.head_channel  <= '0;
				res_q.head_note     <= '0;
				res_q.head_velocity <= '0;
				res_q.head_kind     <= '0;
			end else begin
				res_q.head_time     <= head_ev.time_stamp;
				res_q.head_channel  <= head_ev.channel;
				res_q.head_note     <= head_ev.note;
				res_q.head_velocity <= head_ev.velocity;
				res_q.head_kind     <= head_ev.kind;
			end
		end
	end

endmodule

/* src/midi_gate_event_queue.sv */
// Top level of the MIDI gate event queue: front end, command queue, back end.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive item and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. op selects a MIDI
//   message (note-on, note-off, stop, other) or a pop of the oldest event.
//   Result channel: every input transaction yields exactly one result, shown
//   on result for one cycle with done high. The receiver cannot stall, so
//   it must take the result in that cycle.
//   Path: the command passes the command queue register, then the back end
//   executes it, reads the head from the RAM and registers the result.
//   Sequencing: the back end sequencer (execute, RAM read, emit) works on one
//   transaction at a time around the registered-read event RAM, and takes no
//   new command until it has emitted the result for the last one.
//   A two-entry command queue lets the front take transactions in
//   consecutive cycles until it fills; busy is high while it is full.
//   Reset (arst_n low): empty event ring, all gates closed, command queue
//   empty, no result pending. The event RAM is not cleared; only slots
//   between the read and write pointers are ever reported.
module midi_gate_event_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mgq_pkg::mgq_in_t  item,
	output logic              done,
	output mgq_pkg::mgq_out_t result
);
	import mgq_pkg::*;

	mgq_cmd_t front_cmd;
	mgq_cmd_t back_cmd;
	logic     cmdq_wr;
	logic     cmdq_rd;
	logic     cmdq_full;
	logic     cmdq_nonempty;

	// Classify the transaction and hand it to the command queue.
	mgq_front u_front (
		.start     (start),
		.item      (item),
		.cmdq_full (cmdq_full),
		.busy      (busy),
		.cmdq_wr   (cmdq_wr),
		.cmd       (front_cmd)
	);

	// Hold commands while the back end works on an earlier one.
	mgq_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cmdq_wr),
		.wcmd     (front_cmd),
		.rd       (cmdq_rd),
		.full     (cmdq_full),
		.nonempty (cmdq_nonempty),
		.rcmd     (back_cmd)
	);

	// Advance the ring pointers, update gates, read the head and report it.
	mgq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmdq_nonempty),
		.cmd       (back_cmd),
		.cmd_rd    (cmdq_rd),
		.done      (done),
		.result    (result)
	);

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the MIDI gate event queue: directed table, then random bursts.
`timescale 1ns / 1ps
module testbench;
	import mgq_pkg::*;

	// Cycles without any transaction before the run is declared hung. The slowest
	// legal transaction is the longest random gap plus a wait for a full command queue.
	localparam int IDLE_LIMIT   = 500;
	localparam int RANDOM_ITEMS = 1200;
	// Leave margin after the last owed result for a stray late result.
	localparam int DRAIN_CYCLES = 16;

	// One row of the directed stimulus. When typed is set, want is the result typed
	// in by hand; otherwise the gate/queue tracker supplies it.
	typedef struct {
		mgq_in_t  stim;
		bit       typed;
		mgq_out_t want;
	} stim_row_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	logic     busy;
	mgq_in_t  item   = '0;
	logic     done;
	mgq_out_t result;

	midi_gate_event_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Tracker state: a shadow of the event ring and the three gates.
	mgq_event_t ring_slots [QUEUE_DEPTH];
	qptr_t      ring_wr    = '0;
	qptr_t      ring_rd    = '0;
	logic [2:0] gate_state = '0;

	// Results owed by the block, oldest first.
	mgq_out_t reports_due [$];

	int fail_count  = 0;
	int idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic qptr_t ring_succ(qptr_t p);
		return qptr_next(p);
	endfunction

	// Apply one transaction to the shadow state and return the result the block owes.
	function automatic mgq_out_t track_gates_and_queue(mgq_in_t it);
		mgq_event_t ev;
		mgq_out_t   rep;
		bit         queue_it;
		logic [4:0] ch_off;
		ev       = '0;
		rep      = '0;
		queue_it = 1'b0;
		ch_off   = it.channel - GATE_CH_LO;
		ev.time_stamp = it.time_stamp;
		ev.channel    = it.channel;
		if (it.op == OP_POP) begin
			// Pop on an empty ring does nothing.
			if (ring_wr != ring_rd)
				ring_rd = ring_succ(ring_rd);
		end else begin
			case (it.msg_type)
				MSG_STOP: begin
					// Stop closes every gate and queues with note and velocity zeroed.
					gate_state = '0;
					ev.kind    = KIND_STOP;
					queue_it   = 1'b1;
				end
				MSG_NOTE_ON, MSG_NOTE_OFF: begin
					ev.note     = it.data_one;
					ev.velocity = it.data_two;
					// A note-on at zero velocity is a note-off in disguise.
					ev.kind = (it.msg_type == MSG_NOTE_ON && it.data_two != 7'd0) ?
						KIND_ON : KIND_OFF;
					queue_it = 1'b1;
					if (it.channel >= GATE_CH_LO && it.channel <= GATE_CH_HI)
						gate_state[ch_off[1:0]] = (ev.kind == KIND_ON);
				end
				default: ;
			endcase
			if (queue_it) begin
				// Ring keeps one slot free: drop the oldest event when full.
				if (ring_succ(ring_wr) == ring_rd)
					ring_rd = ring_succ(ring_rd);
				ring_slots[ring_wr] = ev;
				ring_wr = ring_succ(ring_wr);
			end
		end
		rep.gate_bits = gate_state;
		if (ring_wr == ring_rd) begin
			rep.queue_empty = 1'b1;
		end else begin
			rep.head_time     = ring_slots[ring_rd].time_stamp;
			rep.head_channel  = ring_slots[ring_rd].channel;
			rep.head_note     = ring_slots[ring_rd].note;
			rep.head_velocity = ring_slots[ring_rd].velocity;
			rep.head_kind     = ring_slots[ring_rd].kind;
		end
		return rep;
	endfunction

	function automatic mgq_in_t midi_msg(logic op, logic [1:0] kind, logic [4:0] ch,
			logic [6:0] note, logic [6:0] vel, logic [31:0] ts);
		mgq_in_t m;
		m.op         = op;
		m.msg_type   = kind;
		m.channel    = ch;
		m.data_one   = note;
		m.data_two   = vel;
		m.time_stamp = ts;
		return m;
	endfunction

	function automatic mgq_out_t head_report(logic [2:0] gates, logic empty, logic [31:0] ts,
			logic [4:0] ch, logic [6:0] note, logic [6:0] vel, logic [1:0] kind);
		mgq_out_t r;
		r.gate_bits     = gates;
		r.queue_empty   = empty;
		r.head_time     = ts;
		r.head_channel  = ch;
		r.head_note     = note;
		r.head_velocity = vel;
		r.head_kind     = kind;
		return r;
	endfunction

	function automatic stim_row_t make_row(mgq_in_t s, bit typed = 1'b0, mgq_out_t w = '0);
		stim_row_t r;
		r.stim  = s;
		r.typed = typed;
		r.want  = w;
		return r;
	endfunction

	// Send one transaction: hold off for gap cycles, raise start, wait for the
	// handshake, then record what the block owes for it. Returns in the
	// accepting time step so the next transaction can follow back to back.
	task automatic send_transaction(input mgq_in_t it, input bit typed, input mgq_out_t want,
			input int gap);
		mgq_out_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		predicted = track_gates_and_queue(it);
		reports_due.push_back(typed ? want : predicted);
	endtask

	// Check every result against the oldest owed one; the receiver cannot stall,
	// so each done cycle is exactly one transaction.
	always @(posedge clk) begin
		mgq_out_t want;
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				$error("result with no transaction outstanding: %p", result);
				fail_count++;
			end else begin
				want = reports_due.pop_front();
				if (result.gate_bits !== want.gate_bits) begin
					$error("gate_bits: expected %0h, got %0h", want.gate_bits, result.gate_bits);
					fail_count++;
				end
				if (result.queue_empty !== want.queue_empty) begin
					$error("queue_empty: expected %0h, got %0h", want.queue_empty,
						result.queue_empty);
					fail_count++;
				end
				if (result.head_time !== want.head_time) begin
					$error("head_time: expected %0h, got %0h", want.head_time, result.head_time);
					fail_count++;
				end
				if (result.head_channel !== want.head_channel) begin
					$error("head_channel: expected %0d, got %0d", want.head_channel,
						result.head_channel);
					fail_count++;
				end
				if (result.head_note !== want.head_note) begin
					$error("head_note: expected %0d, got %0d", want.head_note, result.head_note);
					fail_count++;
				end
				if (result.head_velocity !== want.head_velocity) begin
					$error("head_velocity: expected %0d, got %0d", want.head_velocity,
						result.head_velocity);
					fail_count++;
				end
				if (result.head_kind !== want.head_kind) begin
					$error("head_kind: expected %0d, got %0d", want.head_kind, result.head_kind);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[midi_gate_event_queue] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t rows [$];
		mgq_in_t   it;
		int        burst_len;
		int        mode;
		int        pick;
		int        counted;
		bit        quiet;

		// Directed part. Pop on an empty ring right after reset, with every
		// ignored field at its maximum.
		rows.push_back(make_row(midi_msg(OP_POP, MSG_OTHER, 5'd31, 7'd127, 7'd127, 32'hFFFF_FFFF),
			1'b1, head_report(3'b000, 1'b1, '0, '0, '0, '0, '0)));
		// First event becomes the head; opens gate 0.
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd3, 7'd127, 7'd127, 32'hFFFF_FFFF),
			1'b1, head_report(3'b001, 1'b0, 32'hFFFF_FFFF, 5'd3, 7'd127, 7'd127, KIND_ON)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd4, 7'd0, 7'd1, 32'd0)));
		// Note-on at zero velocity: queued as note-off, gate stays closed.
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd5, 7'd60, 7'd0, 32'd1)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd5, 7'd61, 7'd100, 32'd2)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_OFF, 5'd4, 7'd0, 7'd127, 32'd3)));
		// Other message type: nothing queued, gates untouched.
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_OTHER, 5'd3, 7'd10, 7'd10, 32'd4)));
		rows.push_back(make_row(midi_msg(OP_POP, MSG_STOP, 5'd0, 7'd0, 7'd0, 32'd5)));
		// Stop with nonzero data: gates clear, data stored as zero.
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_STOP, 5'd0, 7'd127, 7'd127, 32'h8000_0000)));
		// Channels outside the gate range (16, 31, 2, 6), with a note-off on gated channel 3.
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd31, 7'd1, 7'd5, 32'h5555_5555)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd16, 7'd2, 7'd6, 32'hAAAA_AAAA)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_OFF, 5'd3, 7'd3, 7'd7, 32'd6)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd2, 7'd4, 7'd8, 32'd7)));
		rows.push_back(make_row(midi_msg(OP_MSG, MSG_NOTE_ON, 5'd6, 7'd5, 7'd9, 32'd8)));
		// Drain the ten queued events; pop fields that look like a note-on are ignored.
		for (int i = 0; i < 9; i++)
			rows.push_back(make_row(midi_msg(OP_POP, MSG_NOTE_ON, 5'd4, 7'(i), 7'd100, 32'(i))));
		rows.push_back(make_row(midi_msg(OP_POP, MSG_NOTE_ON, 5'd4, 7'd9, 7'd100, 32'd9),
			1'b1, head_report(3'b000, 1'b1, '0, '0, '0, '0, '0)));
		rows.push_back(make_row(midi_msg(OP_POP, MSG_NOTE_OFF, 5'd5, 7'd0, 7'd0, 32'd0),
			1'b1, head_report(3'b000, 1'b1, '0, '0, '0, '0, '0)));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_transaction(rows[i].stim, rows[i].typed, rows[i].want, $urandom_range(0, 13));

		// Random part in bursts: push-heavy bursts overrun the ring, pop-heavy ones
		// drain it to empty, mixed ones wander. Some bursts run with no gaps.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 48);
			mode      = $urandom_range(0, 2);
			quiet     = ($urandom_range(0, 3) == 0);
			repeat (burst_len) begin
				case (mode)
					0:       it.op = ($urandom_range(0, 9) == 0) ? OP_POP : OP_MSG;
					1:       it.op = ($urandom_range(0, 9) < 7) ? OP_POP : OP_MSG;
					default: it.op = $urandom_range(0, 1) ? OP_POP : OP_MSG;
				endcase
				pick = $urandom_range(0, 15);
				if (pick < 7)
					it.msg_type = MSG_NOTE_ON;
				else if (pick < 13)
					it.msg_type = MSG_NOTE_OFF;
				else if (pick < 15)
					it.msg_type = MSG_STOP;
				else
					it.msg_type = MSG_OTHER;
				// At least half the traffic lands on the gated channels.
				it.channel    = $urandom_range(0, 1) ? 5'($urandom_range(3, 5)) :
					5'($urandom_range(0, 31));
				it.data_one   = 7'($urandom_range(0, 127));
				it.data_two   = ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
				it.time_stamp = $urandom();
				// Count only transactions that can change something.
				if (it.op == OP_POP || it.msg_type != MSG_OTHER)
					counted++;
				send_transaction(it, 1'b0, '0, quiet ? 0 : $urandom_range(0, 13));
			end
		end
		start <= 1'b0;

		// Wait for every owed result, then watch a little longer for strays.
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[midi_gate_event_queue] OK");
		else
			$display("[midi_gate_event_queue] ERROR");
		$finish;
	end

endmodule

/* midi_gate_event_queue.f */
src/mgq_pkg.sv
src/mgq_ram.sv
src/mgq_front.sv
src/mgq_cmdq.sv
src/mgq_back.sv
src/midi_gate_event_queue.sv
tb/sv/testbench.sv
